>>> hdl/trajectory_table_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// Trajectory table interpolator assertion macros
// Concurrent assertion shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define TRAJECTORY_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// Antecedent and consequent hold in the same cycle.
`define TTI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("trajectory table interpolator: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define TTI_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("trajectory table interpolator: assertion failed");

`endif

>>> hdl/tti_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator package
// Field widths, codes, command and status types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tti_pkg;

    localparam int DIST_W   = 31;
    localparam int POS_W    = 32;
    localparam int HDG_W    = 15;
    localparam int OHDG_W   = 16;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    // Magnitude of the position difference times magnitude of the distance offset.
    localparam int PROD_W   = POS_W + DIST_W;
    // The scaled step is limited to 2^40 in magnitude.
    localparam int QCLAMP_W = 41;
    localparam int RES_W    = 43;

    localparam logic [DIST_W-1:0] MIN_SPACING_RESET = 31'd5000;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_STORED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_SKIPPED    = 3'd2;
    localparam logic [STAT_W-1:0] ST_DROPPED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_QUERY_OK   = 3'd4;
    localparam logic [STAT_W-1:0] ST_QUERY_NONE = 3'd5;

    localparam logic signed [RES_W-1:0] POS_HI = 43'sd2147483647;
    localparam logic signed [RES_W-1:0] POS_LO = -43'sd2147483648;
    localparam logic signed [RES_W-1:0] HDG_HI = 43'sd32767;
    localparam logic signed [RES_W-1:0] HDG_LO = -43'sd32768;

    typedef struct packed {
        logic [DIST_W-1:0]        path_dist;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HDG_W-1:0]  hdg;
    } entry_t;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_START,
        RD_NEXT,
        RD_LOW
    } rd_sel_t;

    typedef enum logic [2:0] {
        BRK_NONE,
        BRK_FIRST,
        BRK_LAST,
        BRK_UPPER,
        BRK_LOWER
    } brk_op_t;

    typedef enum logic [1:0] {
        LANE_HOLD,
        LANE_PREP,
        LANE_MULT,
        LANE_STEP
    } lane_op_t;

    typedef struct packed {
        logic              capture;
        logic              clear;
        logic              store;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              rd_en;
        rd_sel_t           rd_sel;
        brk_op_t           brk;
        logic              scan_init;
        logic              scan_adv;
        lane_op_t          lane_op;
        logic              emit;
    } tti_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             count_zero;
        logic             table_full;
        logic             load_skip;
        logic             q_le;
        logic             q_ge;
        logic             start_oob;
        logic             next_oob;
        logic             div_done;
        logic             out_busy;
    } tti_sts_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RES_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < POS_LO)
            r = 32'sh8000_0000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    function automatic logic signed [OHDG_W-1:0] sat_hdg(input logic signed [RES_W-1:0] v);
        logic signed [OHDG_W-1:0] r;
        if (v > HDG_HI)
            r = 16'sh7FFF;
        else if (v < HDG_LO)
            r = 16'sh8000;
        else
            r = v[OHDG_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/tti_lerp_lane.sv
// ----------------------------------------------------------------------------
// Interpolation lane
// Forms a + trunc((b - a) * num / den), step clamped to 2^40, with a sign-magnitude
// multiply and a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tti_lerp_lane (
    input  logic                               clk,
    input  tti_pkg::lane_op_t                  op,
    input  logic signed [tti_pkg::POS_W-1:0]   a,
    input  logic signed [tti_pkg::POS_W-1:0]   b,
    input  logic [tti_pkg::DIST_W-1:0]         num_mag,
    input  logic                               num_neg,
    input  logic [tti_pkg::DIST_W-1:0]         den,
    input  logic                               den_pos,
    output logic signed [tti_pkg::RES_W-1:0]   result
);
    import tti_pkg::*;

    localparam logic [PROD_W-1:0] QLIM = PROD_W'(1) << (QCLAMP_W - 1);

    logic signed [POS_W-1:0]  a_reg;
    logic [POS_W-1:0]         dmag_reg;
    logic                     dneg_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [DIST_W-1:0]        rem_reg;

    logic signed [POS_W:0]    diff;
    logic [POS_W-1:0]         dmag_next;
    logic [PROD_W-1:0]        prod;
    logic [DIST_W:0]          rem_shift;
    logic [DIST_W:0]          rem_sub;
    logic                     fits;
    logic [DIST_W-1:0]        rem_next;
    logic [QCLAMP_W-1:0]      qmag;
    logic signed [QCLAMP_W:0] qs;
    logic signed [RES_W-1:0]  a_ext;
    logic signed [RES_W-1:0]  q_ext;

    assign diff      = $signed({b[POS_W-1], b}) - $signed({a[POS_W-1], a});
    assign dmag_next = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
    assign prod      = PROD_W'(dmag_reg) * PROD_W'(num_mag);

    // Restoring division: the dividend shifts out of acc_reg as quotient bits shift in.
    assign rem_shift = {rem_reg, acc_reg[PROD_W-1]};
    assign fits      = (rem_shift >= {1'b0, den});
    assign rem_sub   = rem_shift - {1'b0, den};
    assign rem_next  = fits ? rem_sub[DIST_W-1:0] : rem_shift[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        case (op)
            LANE_PREP:
            begin
                a_reg    <= a;
                dmag_reg <= dmag_next;
                dneg_reg <= diff[POS_W];
            end
            LANE_MULT:
            begin
                acc_reg <= prod;
                neg_reg <= dneg_reg ^ num_neg;
                rem_reg <= '0;
            end
            LANE_STEP:
            begin
                acc_reg <= {acc_reg[PROD_W-2:0], fits};
                rem_reg <= rem_next;
            end
            default:
            begin
            end
        endcase
    end

    assign qmag  = (acc_reg > QLIM) ? QLIM[QCLAMP_W-1:0] : acc_reg[QCLAMP_W-1:0];
    assign qs    = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign a_ext = {{(RES_W - POS_W){a_reg[POS_W-1]}}, a_reg};
    assign q_ext = {{(RES_W - QCLAMP_W - 1){qs[QCLAMP_W]}}, qs};

    // Equal bracket distances give a zero factor.
    assign result = den_pos ? (a_ext + q_ext) : a_ext;

endmodule

>>> hdl/tti_ctrl.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator controller
// Sequences clear, load and query transactions over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tti_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output tti_pkg::tti_cmd_t cmd,
    input  tti_pkg::tti_sts_t sts
);
    import tti_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_EXEC    = 10'b00_0000_0010,
        S_Q_FIRST = 10'b00_0000_0100,
        S_Q_LAST  = 10'b00_0000_1000,
        S_Q_SCAN  = 10'b00_0001_0000,
        S_Q_LOW   = 10'b00_0010_0000,
        S_PREP    = 10'b00_0100_0000,
        S_MULT    = 10'b00_1000_0000,
        S_DIV     = 10'b01_0000_0000,
        S_FINISH  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RD_FIRST;
        cmd.brk     = BRK_NONE;
        cmd.lane_op = LANE_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.action)
                    ACT_CLEAR:
                    begin
                        cmd.clear       = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_CLEARED;
                        state_next      = S_FINISH;
                    end
                    ACT_LOAD:
                    begin
                        cmd.set_status = 1'b1;
                        if (sts.load_skip)
                            cmd.status_code = ST_SKIPPED;
                        else if (sts.table_full)
                            cmd.status_code = ST_DROPPED;
                        else
                        begin
                            cmd.store       = 1'b1;
                            cmd.status_code = ST_STORED;
                        end
                        state_next = S_FINISH;
                    end
                    ACT_QUERY:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_QUERY_NONE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_FIRST;
                            state_next = S_Q_FIRST;
                        end
                    end
                    default:
                    begin
                        // The unused action code produces no result.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_Q_FIRST:
            begin
                if (sts.q_le)
                begin
                    cmd.brk    = BRK_FIRST;
                    state_next = S_PREP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = S_Q_LAST;
                end
            end
            S_Q_LAST:
            begin
                if (sts.q_ge)
                begin
                    cmd.brk    = BRK_LAST;
                    state_next = S_PREP;
                end
                else if (sts.start_oob)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_QUERY_NONE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_START;
                    cmd.scan_init = 1'b1;
                    state_next    = S_Q_SCAN;
                end
            end
            S_Q_SCAN:
            begin
                if (!sts.q_ge)
                begin
                    cmd.brk    = BRK_UPPER;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LOW;
                    state_next = S_Q_LOW;
                end
                else if (sts.next_oob)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_QUERY_NONE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_NEXT;
                    cmd.scan_adv = 1'b1;
                end
            end
            S_Q_LOW:
            begin
                cmd.brk    = BRK_LOWER;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.lane_op     = LANE_PREP;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_QUERY_OK;
                state_next      = S_MULT;
            end
            S_MULT:
            begin
                cmd.lane_op = LANE_MULT;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.lane_op = LANE_STEP;
                if (sts.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/tti_datapath.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator datapath
// Sample memory, bracket registers, three interpolation lanes and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tti_datapath #(
    parameter  int TABLE_DEPTH = 64,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tti_pkg::tti_cmd_t                   cmd,
    output tti_pkg::tti_sts_t                   sts,
    input  logic                                cfg_valid,
    input  logic [tti_pkg::DIST_W-1:0]          cfg_data,
    input  logic [tti_pkg::ACT_W-1:0]           in_action,
    input  logic [tti_pkg::DIST_W-1:0]          in_dist,
    input  logic signed [tti_pkg::POS_W-1:0]    in_x,
    input  logic signed [tti_pkg::POS_W-1:0]    in_y,
    input  logic signed [tti_pkg::HDG_W-1:0]    in_hdg,
    input  logic [tti_pkg::DIST_W-1:0]          in_qdist,
    input  logic [IDX_W-1:0]                    in_start,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [tti_pkg::STAT_W-1:0]          out_status,
    output logic [IDX_W-1:0]                    out_lower,
    output logic [IDX_W-1:0]                    out_upper,
    output logic signed [tti_pkg::POS_W-1:0]    out_x,
    output logic signed [tti_pkg::POS_W-1:0]    out_y,
    output logic signed [tti_pkg::OHDG_W-1:0]   out_hdg,
    output logic [CNT_W-1:0]                    out_count
);
    import tti_pkg::*;

    localparam int DIV_CNT_W = $clog2(PROD_W);

    entry_t sample_mem [TABLE_DEPTH];

    logic [DIST_W-1:0]        min_spacing_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [DIST_W-1:0]        last_reg;
    logic [ACT_W-1:0]         action_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  y_reg;
    logic signed [HDG_W-1:0]  hdg_reg;
    logic [DIST_W-1:0]        qdist_reg;
    logic [IDX_W-1:0]         start_reg;
    entry_t                   rd_reg;
    entry_t                   lo_entry_reg;
    entry_t                   up_entry_reg;
    logic [IDX_W-1:0]         lo_idx_reg;
    logic [IDX_W-1:0]         up_idx_reg;
    logic [IDX_W-1:0]         scan_reg;
    logic [DIST_W-1:0]        num_mag_reg;
    logic                     num_neg_reg;
    logic [DIST_W-1:0]        den_reg;
    logic                     den_pos_reg;
    logic [DIST_W-1:0]        num_mag_next;
    logic                     num_neg_next;
    logic [DIST_W-1:0]        den_next;
    logic                     den_pos_next;
    logic [DIST_W-1:0]        lo_up_gap;
    logic [DIST_W-1:0]        q_lo_gap;
    logic [DIST_W-1:0]        lo_q_gap;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     out_valid_reg;

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W:0]           scan_inc;
    logic [IDX_W-1:0]         scan_lo;
    logic [IDX_W:0]           count_ext;
    logic [DIST_W:0]          spacing_bound;
    logic                     query_ok;
    logic signed [POS_W-1:0]  lo_hdg_ext;
    logic signed [POS_W-1:0]  up_hdg_ext;
    logic signed [RES_W-1:0]  res_x;
    logic signed [RES_W-1:0]  res_y;
    logic signed [RES_W-1:0]  res_hdg;

    assign last_idx      = IDX_W'(count_reg - 1'b1);
    assign scan_inc      = {1'b0, scan_reg} + 1'b1;
    assign scan_lo       = (scan_reg == '0) ? '0 : scan_reg - 1'b1;
    assign count_ext     = (IDX_W + 1)'(count_reg);
    assign spacing_bound = {1'b0, last_reg} + {1'b0, min_spacing_reg};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = last_idx;
            RD_START: rd_addr = start_reg;
            RD_NEXT:  rd_addr = scan_inc[IDX_W-1:0];
            RD_LOW:   rd_addr = scan_lo;
            default:  rd_addr = '0;
        endcase
    end

    assign sts.action     = action_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    // The step from the last kept sample is short of min_spacing.
    assign sts.load_skip  = (count_reg != '0) && ({1'b0, dist_reg} < spacing_bound);
    assign sts.q_le       = (qdist_reg <= rd_reg.path_dist);
    assign sts.q_ge       = (qdist_reg >= rd_reg.path_dist);
    assign sts.start_oob  = ({1'b0, start_reg} >= count_ext);
    assign sts.next_oob   = (scan_inc >= count_ext);
    assign sts.div_done   = (div_cnt_reg == DIV_CNT_W'(PROD_W - 1));
    assign sts.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            sample_mem[count_reg[IDX_W-1:0]] <= '{path_dist: dist_reg, x: x_reg, y: y_reg,
                                                  hdg: hdg_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_reg <= sample_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_spacing_reg <= MIN_SPACING_RESET;
            count_reg       <= '0;
            last_reg        <= '0;
            action_reg      <= ACT_CLEAR;
            status_reg      <= ST_CLEARED;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                min_spacing_reg <= cfg_data;
            if (cmd.capture)
                action_reg <= in_action;
            if (cmd.clear)
            begin
                count_reg <= '0;
                last_reg  <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
                last_reg  <= dist_reg;
            end
            if (cmd.set_status)
                status_reg <= cmd.status_code;
            if (cmd.lane_op == LANE_MULT)
                div_cnt_reg <= '0;
            else if (cmd.lane_op == LANE_STEP)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dist_reg  <= in_dist;
            x_reg     <= in_x;
            y_reg     <= in_y;
            hdg_reg   <= in_hdg;
            qdist_reg <= in_qdist;
            start_reg <= in_start;
        end
        if (cmd.scan_init)
            scan_reg <= start_reg;
        else if (cmd.scan_adv)
            scan_reg <= scan_inc[IDX_W-1:0];
        case (cmd.brk)
            BRK_FIRST:
            begin
                lo_idx_reg   <= '0;
                up_idx_reg   <= '0;
                lo_entry_reg <= rd_reg;
                up_entry_reg <= rd_reg;
            end
            BRK_LAST:
            begin
                lo_idx_reg   <= last_idx;
                up_idx_reg   <= last_idx;
                lo_entry_reg <= rd_reg;
                up_entry_reg <= rd_reg;
            end
            BRK_UPPER:
            begin
                lo_idx_reg   <= scan_lo;
                up_idx_reg   <= scan_reg;
                up_entry_reg <= rd_reg;
            end
            BRK_LOWER:
            begin
                lo_entry_reg <= rd_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.lane_op == LANE_PREP)
        begin
            num_mag_reg <= num_mag_next;
            num_neg_reg <= num_neg_next;
            den_reg     <= den_next;
            den_pos_reg <= den_pos_next;
        end
    end

    // Offset of the query from the lower sample; negative when extrapolating.
    assign q_lo_gap     = qdist_reg - lo_entry_reg.path_dist;
    assign lo_q_gap     = lo_entry_reg.path_dist - qdist_reg;
    assign lo_up_gap    = up_entry_reg.path_dist - lo_entry_reg.path_dist;
    assign num_neg_next = (qdist_reg < lo_entry_reg.path_dist);
    assign num_mag_next = num_neg_next ? lo_q_gap : q_lo_gap;
    assign den_pos_next = (up_entry_reg.path_dist > lo_entry_reg.path_dist);
    assign den_next     = lo_up_gap;

    assign lo_hdg_ext = {{(POS_W - HDG_W){lo_entry_reg.hdg[HDG_W-1]}}, lo_entry_reg.hdg};
    assign up_hdg_ext = {{(POS_W - HDG_W){up_entry_reg.hdg[HDG_W-1]}}, up_entry_reg.hdg};

    tti_lerp_lane u_lane_x (
        .clk     (clk),
        .op      (cmd.lane_op),
        .a       (lo_entry_reg.x),
        .b       (up_entry_reg.x),
        .num_mag (num_mag_reg),
        .num_neg (num_neg_reg),
        .den     (den_reg),
        .den_pos (den_pos_reg),
        .result  (res_x)
    );

    tti_lerp_lane u_lane_y (
        .clk     (clk),
        .op      (cmd.lane_op),
        .a       (lo_entry_reg.y),
        .b       (up_entry_reg.y),
        .num_mag (num_mag_reg),
        .num_neg (num_neg_reg),
        .den     (den_reg),
        .den_pos (den_pos_reg),
        .result  (res_y)
    );

    tti_lerp_lane u_lane_hdg (
        .clk     (clk),
        .op      (cmd.lane_op),
        .a       (lo_hdg_ext),
        .b       (up_hdg_ext),
        .num_mag (num_mag_reg),
        .num_neg (num_neg_reg),
        .den     (den_reg),
        .den_pos (den_pos_reg),
        .result  (res_hdg)
    );

    assign query_ok = (status_reg == ST_QUERY_OK);

    // Only a successful query carries indices and an interpolated pose.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status <= status_reg;
            out_lower  <= query_ok ? lo_idx_reg : '0;
            out_upper  <= query_ok ? up_idx_reg : '0;
            out_x      <= query_ok ? sat_pos(res_x) : '0;
            out_y      <= query_ok ? sat_pos(res_y) : '0;
            out_hdg    <= query_ok ? sat_hdg(res_hdg) : '0;
            out_count  <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/trajectory_table_interpolator_core.sv
// Sequence: a clear or load sets its status and then emits its result. A query at or
// beyond an end of the table is answered by the first or last sample; any other is looked
// up by the one-entry-per-cycle table scan forward from start_index (up to TABLE_DEPTH
// entries). An answered query then runs the 63-step divider. One item is in work at a time;
// the next transaction is taken once the result sits in the output register. Reset is
// asynchronous, active low: count, last distance and output valid clear, min_spacing is 5000.
// ----------------------------------------------------------------------------
// Trajectory table interpolator core
// Stream wrapper around the controller and datapath, with field packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trajectory_table_interpolator_core_macros.svh"

module trajectory_table_interpolator_core #(
    parameter  int TABLE_DEPTH = 64,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
    localparam int S_BITS      = 3 * tti_pkg::DIST_W + 2 * tti_pkg::POS_W
                                 + tti_pkg::HDG_W + IDX_W - tti_pkg::DIST_W,
    localparam int S_TDATA_W   = ((S_BITS + 7) / 8) * 8,
    localparam int M_BITS      = 2 * IDX_W + 2 * tti_pkg::POS_W + tti_pkg::OHDG_W + CNT_W,
    localparam int M_TDATA_W   = ((M_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // cfg_data: min_spacing
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tti_pkg::DIST_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, from bit 0: entry_dist, entry_x, entry_y, entry_heading, query_dist,
    // start_index, zero fill
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // s_tuser: action
    input  logic [tti_pkg::ACT_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0: lower_index, upper_index, out_x, out_y, out_heading,
    // entry_count, zero fill
    output logic [M_TDATA_W-1:0]          m_tdata,
    // m_tuser: status
    output logic [tti_pkg::STAT_W-1:0]    m_tuser
);
    import tti_pkg::*;

    localparam int OFF_X  = DIST_W;
    localparam int OFF_Y  = OFF_X + POS_W;
    localparam int OFF_H  = OFF_Y + POS_W;
    localparam int OFF_Q  = OFF_H + HDG_W;
    localparam int OFF_S  = OFF_Q + DIST_W;

    tti_cmd_t                 cmd;
    tti_sts_t                 sts;
    logic [DIST_W-1:0]        in_dist;
    logic signed [POS_W-1:0]  in_x;
    logic signed [POS_W-1:0]  in_y;
    logic signed [HDG_W-1:0]  in_hdg;
    logic [DIST_W-1:0]        in_qdist;
    logic [IDX_W-1:0]         in_start;
    logic [STAT_W-1:0]        out_status;
    logic [IDX_W-1:0]         out_lower;
    logic [IDX_W-1:0]         out_upper;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [OHDG_W-1:0] out_hdg;
    logic [CNT_W-1:0]         out_count;

    assign in_dist  = s_tdata[DIST_W-1:0];
    assign in_x     = s_tdata[OFF_X +: POS_W];
    assign in_y     = s_tdata[OFF_Y +: POS_W];
    assign in_hdg   = s_tdata[OFF_H +: HDG_W];
    assign in_qdist = s_tdata[OFF_Q +: DIST_W];
    assign in_start = s_tdata[OFF_S +: IDX_W];

    // Register writes must arrive only while the block is idle; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    tti_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tti_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_action  (s_tuser),
        .in_dist    (in_dist),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_hdg     (in_hdg),
        .in_qdist   (in_qdist),
        .in_start   (in_start),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_lower  (out_lower),
        .out_upper  (out_upper),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_hdg    (out_hdg),
        .out_count  (out_count)
    );

    assign m_tdata = M_TDATA_W'({out_count, out_hdg, out_y, out_x, out_upper, out_lower});
    assign m_tuser = out_status;

    `TTI_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `TTI_ASSERT_IMP(a_count_bound, clk, rst_n, m_tvalid, out_count <= CNT_W'(TABLE_DEPTH))
    `TTI_ASSERT_IMP(a_bracket_order, clk, rst_n, m_tvalid && (out_status == ST_QUERY_OK), out_lower <= out_upper)
    `TTI_ASSERT_IMP(a_zero_pose, clk, rst_n, m_tvalid && (out_status != ST_QUERY_OK), (out_x == '0) && (out_y == '0) && (out_hdg == '0))

endmodule

>>> tb/trajectory_table_interpolator_core_tb.sv
// ----------------------------------------------------------------------------
// Trajectory table interpolator testbench
// Loads path tables, queries them and checks every result against an
// in-bench model of the table, the bracketing scan and the saturated lerp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trajectory_table_interpolator_core_tb;

    import tti_pkg::*;

    localparam int S_TDATA_W     = 152;
    localparam int M_TDATA_W     = 104;
    localparam int TRACK_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam longint DIST_MAX  = 64'd2147483647;
    localparam int POS_MAX       = 32'sh7FFF_FFFF;
    localparam int POS_MIN       = 32'sh8000_0000;
    localparam int HDG_LIMIT     = 12868;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [DIST_W-1:0]       load_dist;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [HDG_W-1:0] hdg;
        logic [DIST_W-1:0]       qdist;
        logic [5:0]              start;
    } track_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [5:0]        lower;
        logic [5:0]        upper;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [15:0]       hdg;
        logic [6:0]        count;
    } track_reply_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [DIST_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [ACT_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    track_cmd_t   cmd_backlog[$];
    track_reply_t awaited_replies[$];
    track_cmd_t   offered;

    // Model of the sample table and its registers
    longint trk_dist[TRACK_DEPTH];
    longint trk_x[TRACK_DEPTH];
    longint trk_y[TRACK_DEPTH];
    longint trk_hdg[TRACK_DEPTH];
    int     track_count = 0;
    longint last_dist   = 0;
    longint spacing     = 5000;

    int  error_count = 0;
    int  cycle_count = 0;
    int  src_gap     = 0;
    int  sink_stall  = 0;
    bit  src_mode    = 1'b1;
    bit  sink_mode   = 1'b1;
    bit  sink_hold   = 1'b0;
    bit  pressure_on = 1'b0;

    trajectory_table_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Linear blend with the scaled step limited to 2^40; a zero span keeps the lower value.
    function automatic longint blend(input longint a, input longint b, input longint num,
                                     input longint den);
        longint s;
        if (den <= 0)
            return a;
        s = ((b - a) * num) / den;
        s = clamp_to(s, -(64'sd1 <<< 40), 64'sd1 <<< 40);
        return a + s;
    endfunction

    task automatic track_step(input track_cmd_t c);
        track_reply_t r;
        longint       d;
        longint       q;
        longint       num;
        longint       den;
        int           lo;
        int           up;
        bit           hit;
        r   = '0;
        lo  = 0;
        up  = 0;
        hit = 1'b0;
        if (c.action == ACT_UNUSED)
            return;
        if (c.action == ACT_CLEAR) begin
            track_count = 0;
            last_dist   = 0;
            r.status    = ST_CLEARED;
        end
        else if (c.action == ACT_LOAD) begin
            d = longint'(c.load_dist);
            if (track_count != 0 && (d - last_dist) < spacing) begin
                r.status = ST_SKIPPED;
            end
            else if (track_count >= TRACK_DEPTH) begin
                r.status = ST_DROPPED;
            end
            else begin
                trk_dist[track_count] = d;
                trk_x[track_count]    = longint'(c.x);
                trk_y[track_count]    = longint'(c.y);
                trk_hdg[track_count]  = longint'(c.hdg);
                track_count++;
                last_dist = d;
                r.status  = ST_STORED;
            end
        end
        else begin
            q = longint'(c.qdist);
            if (track_count != 0) begin
                if (q <= trk_dist[0]) begin
                    hit = 1'b1;
                end
                else if (q >= trk_dist[track_count-1]) begin
                    lo  = track_count - 1;
                    up  = lo;
                    hit = 1'b1;
                end
                else begin
                    for (int i = int'(c.start); i < track_count; i++) begin
                        if (!hit && trk_dist[i] > q) begin
                            up  = i;
                            lo  = (i == 0) ? 0 : i - 1;
                            hit = 1'b1;
                        end
                    end
                end
            end
            if (hit) begin
                num      = q - trk_dist[lo];
                den      = trk_dist[up] - trk_dist[lo];
                r.x      = 32'(clamp_to(blend(trk_x[lo], trk_x[up], num, den),
                                        longint'(POS_MIN), longint'(POS_MAX)));
                r.y      = 32'(clamp_to(blend(trk_y[lo], trk_y[up], num, den),
                                        longint'(POS_MIN), longint'(POS_MAX)));
                r.hdg    = 16'(clamp_to(blend(trk_hdg[lo], trk_hdg[up], num, den),
                                        -32768, 32767));
                r.lower  = 6'(lo);
                r.upper  = 6'(up);
                r.status = ST_QUERY_OK;
            end
            else begin
                r.status = ST_QUERY_NONE;
            end
        end
        r.count = 7'(track_count);
        awaited_replies.push_back(r);
    endtask

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Sender: one transaction offered at a time, with a random gap after each when src_mode is set.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                track_step(offered);
            if (s_tvalid && !s_tready) begin
                // hold the current transaction
            end
            else if (src_gap != 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (cmd_backlog.size() != 0) begin
                offered  = cmd_backlog.pop_front();
                s_tdata  <= {5'b0, offered.start, offered.qdist, offered.hdg,
                             offered.y, offered.x, offered.load_dist};
                s_tuser  <= offered.action;
                s_tvalid <= 1'b1;
                src_gap  <= pick_gap(src_mode);
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
        if (want !== seen) begin
            error_count++;
            $display("%0t ns ERROR %s: expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    task automatic check_reply();
        track_reply_t want;
        if (awaited_replies.size() == 0) begin
            error_count++;
            $display("%0t ns ERROR unexpected result: status %0h, data %0h",
                     $time, m_tuser, m_tdata);
            return;
        end
        want = awaited_replies.pop_front();
        flag_field("status", want.status, m_tuser);
        flag_field("lower_index", want.lower, m_tdata[5:0]);
        flag_field("upper_index", want.upper, m_tdata[11:6]);
        flag_field("out_x", want.x, m_tdata[43:12]);
        flag_field("out_y", want.y, m_tdata[75:44]);
        flag_field("out_heading", want.hdg, m_tdata[91:76]);
        flag_field("entry_count", want.count, m_tdata[98:92]);
    endtask

    // Receiver: checks each result transaction and stalls at random when sink_mode is set, or while sink_hold is set.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_reply();
            if (sink_hold) begin
                m_tready <= 1'b0;
            end
            else if (sink_stall != 0) begin
                m_tready   <= 1'b0;
                sink_stall <= sink_stall - 1;
            end
            else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_stall <= pick_gap(sink_mode);
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        wait (pressure_on);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trajectory_table_interpolator_core: mismatch");
            $finish;
        end
    end

    function automatic track_cmd_t rand_cmd();
        track_cmd_t c;
        c.action    = ACT_W'($urandom_range(0, 2));
        c.load_dist = DIST_W'($urandom);
        c.x         = $urandom;
        c.y         = $urandom;
        c.hdg       = HDG_W'(int'($urandom_range(0, 2 * HDG_LIMIT)) - HDG_LIMIT);
        c.qdist     = DIST_W'($urandom);
        c.start     = 6'($urandom_range(0, 63));
        return c;
    endfunction

    task automatic add_op(input logic [ACT_W-1:0] a);
        track_cmd_t c;
        c        = rand_cmd();
        c.action = a;
        cmd_backlog.push_back(c);
    endtask

    task automatic add_load(input longint d, input int x, input int y, input int h);
        track_cmd_t c;
        c           = rand_cmd();
        c.action    = ACT_LOAD;
        c.load_dist = d[DIST_W-1:0];
        c.x         = x;
        c.y         = y;
        c.hdg       = HDG_W'(h);
        cmd_backlog.push_back(c);
    endtask

    task automatic add_query(input longint q, input int s);
        track_cmd_t c;
        c        = rand_cmd();
        c.action = ACT_QUERY;
        c.qdist  = q[DIST_W-1:0];
        c.start  = 6'(s);
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_settled();
        while (cmd_backlog.size() != 0 || s_tvalid || awaited_replies.size() != 0)
            @(posedge clk);
        // a trailing unused action gives no result, so allow its latency too
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spacing(input longint v);
        @(posedge clk);
        cfg_data  <= v[DIST_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        spacing = v;
    endtask

    // A well-formed track: optional clear, non-decreasing loads, then queries around it.
    task automatic build_track(inout int made);
        longint d;
        longint d_first;
        longint step;
        longint q;
        int     n_loads;
        int     n_queries;
        int     x;
        int     y;
        int     r;
        int     s;
        if ($urandom_range(0, 4) != 0)
            add_op(ACT_CLEAR);
        d = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 32'h7FFF_FFFF))
                                        : longint'($urandom_range(0, 3000));
        d_first   = d;
        n_loads   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 16);
        n_queries = $urandom_range(1, 10);
        x = $urandom;
        y = $urandom;
        for (int i = 0; i < n_loads; i++) begin
            if (i != 0) begin
                if ($urandom_range(0, 6) == 0)
                    step = longint'($urandom_range(0, 32'(clamp_to(spacing, 0, DIST_MAX))));
                else
                    step = spacing + longint'($urandom_range(0, 32'(spacing / 2 + 2000)));
                d = clamp_to(d + step, 0, DIST_MAX);
            end
            if ($urandom_range(0, 1) == 0) begin
                x = x + int'($urandom_range(0, 200000)) - 100000;
                y = y + int'($urandom_range(0, 200000)) - 100000;
            end
            else begin
                x = $urandom;
                y = $urandom;
            end
            add_load(d, x, y, int'($urandom_range(0, 2 * HDG_LIMIT)) - HDG_LIMIT);
        end
        for (int i = 0; i < n_queries; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                q = longint'($urandom_range(0, 32'(d_first)));
            else if (r == 1)
                q = longint'($urandom_range(32'(d), 32'h7FFF_FFFF));
            else
                q = longint'($urandom_range(32'(d_first), 32'(d)));
            r = $urandom_range(0, 9);
            if (r < 6)
                s = 0;
            else if (r < 8)
                s = $urandom_range(0, (n_loads > 63) ? 63 : n_loads);
            else
                s = $urandom_range(0, 63);
            add_query(q, s);
        end
        made += 1 + n_loads + n_queries;
    endtask

    task automatic build_phase(input int n_items);
        int         made;
        int         n_noise;
        track_cmd_t c;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                n_noise = $urandom_range(3, 10);
                for (int i = 0; i < n_noise; i++) begin
                    c = rand_cmd();
                    if ($urandom_range(0, 19) == 0)
                        c.action = ACT_UNUSED;
                    else
                        made++;
                    cmd_backlog.push_back(c);
                end
            end
            else begin
                build_track(made);
            end
        end
    endtask

    initial begin
        longint phase_spacing[5];
        int     phase_items[5];
        phase_spacing = '{DIST_MAX, longint'($urandom_range(1, 20000)), 5000, 0,
                          longint'($urandom_range(32'd1 << 20, 32'd1 << 26))};
        phase_items   = '{120, 330, 300, 300, 300};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset spacing: ends of the table, skips, extrapolation and saturation.
        add_query(1000, 0);
        add_op(ACT_UNUSED);
        add_load(1000, POS_MAX, POS_MIN, HDG_LIMIT);
        add_load(3000, 1, 2, 3);
        add_load(6000, POS_MIN, POS_MAX, -HDG_LIMIT);
        add_load(0, 4, 5, 6);
        add_load(11000, POS_MAX, POS_MIN, HDG_LIMIT);
        add_load(16000, POS_MIN, POS_MAX, -HDG_LIMIT);
        add_load(DIST_MAX, 0, -1, 0);
        add_query(0, 0);
        add_query(1000, 0);
        add_query(DIST_MAX, 63);
        add_query(3500, 0);
        add_query(3500, 2);
        add_query(1500, 3);
        add_query(8000, 63);
        wait_settled();

        // Zero spacing: equal distances, a zero span and the clamped step.
        write_spacing(0);
        add_op(ACT_CLEAR);
        add_load(0, POS_MIN, POS_MAX, -HDG_LIMIT);
        add_load(1000000, POS_MIN, POS_MAX, -HDG_LIMIT);
        add_load(1000001, POS_MAX, POS_MIN, HDG_LIMIT);
        add_load(1000001, 7, 8, 9);
        add_load(2000000, -7, -8, -9);
        add_query(1, 2);
        add_query(1, 3);
        add_query(1, 4);
        wait_settled();

        for (int p = 0; p < 5; p++) begin
            write_spacing(phase_spacing[p]);
            src_mode  = (p != 1) && (p != 2);
            sink_mode = (p != 2) && (p != 3);
            if (p == 2)
                pressure_on = 1'b1;
            build_phase(phase_items[p]);
            wait_settled();
        end

        if (error_count == 0 && awaited_replies.size() == 0)
            $display("trajectory_table_interpolator_core: match");
        else
            $display("trajectory_table_interpolator_core: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tti_pkg.sv
hdl/tti_lerp_lane.sv
hdl/tti_ctrl.sv
hdl/tti_datapath.sv
hdl/trajectory_table_interpolator_core.sv
tb/trajectory_table_interpolator_core_tb.sv
